// ----- hw/rtl/iic_pkg.sv -----
// ----------------------------------------------------------------------------
// iic_pkg
// Shared constants and types for the interval index classifier.
// ----------------------------------------------------------------------------
package iic_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int VALUE_BITS  = 32;
    localparam int INDEX_BITS  = 7;

    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W  = $clog2(MAX_ENTRIES + 2);

    localparam int IN_DATA_W  = ((VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((INDEX_BITS + VALUE_BITS + 7) / 8) * 8;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                  op;
        logic [VALUE_BITS-1:0] value;
        logic                  last;
    } t_req;

    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        logic [VALUE_BITS-1:0] value;
    } t_res;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [VALUE_BITS-1:0] wdata;
        logic [ADDR_W-1:0]     raddr;
    } t_ram_cmd;

endpackage

// ----- hw/rtl/iic_ram.sv -----
// ----------------------------------------------------------------------------
// iic_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module iic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/iic_engine.sv -----
// ----------------------------------------------------------------------------
// iic_engine
// Sequencer that scans, inserts into and searches the sorted boundary table
// through one shared signed comparator.
// ----------------------------------------------------------------------------
module iic_engine (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    output logic                             o_req_ready,
    input  iic_pkg::t_req                    i_req,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output iic_pkg::t_res                    o_res,
    output iic_pkg::t_ram_cmd                o_ram,
    input  logic [iic_pkg::VALUE_BITS-1:0]   i_ram_rdata
);
    import iic_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_SHRD = 3'd3;
    localparam logic [2:0] S_SHWR = 3'd4;
    localparam logic [2:0] S_RES  = 3'd5;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic [2:0]            r_state,     n_state;
    logic                  r_list_open, n_list_open;
    logic [CNT_W-1:0]      r_ucount,    n_ucount;
    logic [CNT_W-1:0]      r_rcount,    n_rcount;
    logic [CNT_W-1:0]      r_i,         n_i;
    logic [CNT_W-1:0]      r_k,         n_k;
    logic [VALUE_BITS-1:0] r_key,       n_key;
    logic                  r_op,        n_op;

    logic                  w_lt;
    logic                  w_eq;
    logic [CNT_W-1:0]      w_km1;
    logic [CNT_W-1:0]      w_eff_u;
    logic [CNT_W-1:0]      w_eff_r;
    logic [IDX_W-1:0]      w_idx;

    // shared comparator: stored key against table word
    assign w_lt  = $signed(r_key) < $signed(i_ram_rdata);
    assign w_eq  = r_key == i_ram_rdata;
    assign w_km1 = r_k - CNT_ONE;
    assign w_idx = IDX_W'(r_i) + IDX_W'(1);

    assign w_eff_u = r_list_open ? r_ucount : '0;
    assign w_eff_r = r_list_open ? r_rcount : '0;

    assign o_req_ready = r_state == S_IDLE;
    assign o_res_valid = r_state == S_RES;
    assign o_res.index = INDEX_BITS'(w_idx);
    assign o_res.value = r_key;

    always_comb begin
        n_state     = r_state;
        n_list_open = r_list_open;
        n_ucount    = r_ucount;
        n_rcount    = r_rcount;
        n_i         = r_i;
        n_k         = r_k;
        n_key       = r_key;
        n_op        = r_op;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_i[ADDR_W-1:0];
        o_ram.wdata = r_key;
        o_ram.raddr = r_i[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_key = i_req.value;
                    n_op  = i_req.op;
                    n_i   = '0;
                    if (i_req.op == OP_QUERY) begin
                        n_state = S_SCAN;
                    end else begin
                        n_ucount    = w_eff_u;
                        n_rcount    = w_eff_r;
                        n_list_open = !i_req.last;
                        if (w_eff_r < CNT_MAX) begin
                            n_rcount = w_eff_r + CNT_ONE;
                            n_state  = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_i < r_ucount) begin
                    n_state = S_CMP;
                end else if (r_op == OP_QUERY) begin
                    n_state = S_RES;
                end else begin
                    n_k     = r_ucount;
                    n_state = S_SHRD;
                end
            end
            S_CMP: begin
                if (r_op == OP_QUERY) begin
                    if (w_lt) begin
                        n_state = S_RES;
                    end else begin
                        n_i     = r_i + CNT_ONE;
                        n_state = S_SCAN;
                    end
                end else if (w_eq) begin
                    n_state = S_IDLE;
                end else if (w_lt) begin
                    n_k     = r_ucount;
                    n_state = S_SHRD;
                end else begin
                    n_i     = r_i + CNT_ONE;
                    n_state = S_SCAN;
                end
            end
            S_SHRD: begin
                o_ram.raddr = w_km1[ADDR_W-1:0];
                if (r_ucount >= CNT_MAX) begin
                    n_state = S_IDLE;
                end else if (r_k > r_i) begin
                    n_state = S_SHWR;
                end else begin
                    o_ram.we = 1'b1;
                    n_ucount = r_ucount + CNT_ONE;
                    n_state  = S_IDLE;
                end
            end
            S_SHWR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_k[ADDR_W-1:0];
                o_ram.wdata = i_ram_rdata;
                n_k         = w_km1;
                n_state     = S_SHRD;
            end
            S_RES: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_list_open <= 1'b0;
            r_ucount    <= '0;
            r_rcount    <= '0;
            r_i         <= '0;
            r_k         <= '0;
        end else begin
            r_state     <= n_state;
            r_list_open <= n_list_open;
            r_ucount    <= n_ucount;
            r_rcount    <= n_rcount;
            r_i         <= n_i;
            r_k         <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_op  <= n_op;
    end

endmodule

// ----- hw/rtl/interval_index_classifier.sv -----
// ----------------------------------------------------------------------------
// interval_index_classifier
// Sorted boundary table with interval lookup on signed Q16.16 values.
// ----------------------------------------------------------------------------
// The slave stream carries one item per transaction: tuser is the opcode
// (0 load, 1 query), tdata the value and tlast closes a boundary list.
// Loads build a sorted table of distinct boundaries, up to 64 per list;
// the first load after a closed list starts a fresh table. A query returns
// one master transaction holding the 1-based index of the first boundary
// above the value (count plus one if none) and the value itself.
// One item is processed at a time; o_s_axis_tready is low while it runs.
// A query reads and compares stored boundaries in order (S_SCAN, S_CMP)
// until one lies above the value or the table ends; then the result
// enters the output register. A load compares the same way and stops on
// an equal boundary, then shifts each larger entry up (S_SHRD, S_SHWR) and
// writes the value; a dropped load is accepted without leaving S_IDLE.
// The steps follow from the one RAM read port and its registered read.
// A finished result waits in the output register while a new item is
// accepted; a stalled receiver holds a second result inside the sequencer.
// Reset empties the table and closes any open list; no clearing pass.
// ----------------------------------------------------------------------------
module interval_index_classifier (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // value
    input  logic [iic_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // opcode
    input  logic                              i_s_axis_tuser,
    input  logic                              i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // index, passed_value
    output logic [iic_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);
    import iic_pkg::*;

    t_req                  w_req;
    t_res                  w_res;
    t_ram_cmd              w_ram;
    logic [VALUE_BITS-1:0] w_rdata;
    logic                  w_res_valid;
    logic                  w_res_ready;
    logic                  w_req_ready;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    assign w_req.op    = i_s_axis_tuser;
    assign w_req.value = i_s_axis_tdata[VALUE_BITS-1:0];
    assign w_req.last  = i_s_axis_tlast;

    assign w_res_ready     = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_req_ready;

    iic_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (w_req_ready),
        .i_req       (w_req),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_ram       (w_ram),
        .i_ram_rdata (w_rdata)
    );

    iic_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ENTRIES),
        .AW    (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out_data <= OUT_DATA_W'({w_res.value, w_res.index});
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == OP_QUERY))
        |=> !o_s_axis_tready)
        else $error("ready after accepted query transaction");

    a_index_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[INDEX_BITS-1:0] != '0))
        else $error("zero interval index");

    a_out_from_engine : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_res_valid))
        else $error("output valid without engine result");
`endif

endmodule

// ----- tb/interval_index_classifier_test.sv -----
// ----------------------------------------------------------------------------
// interval_index_classifier_test
// Self-checking stream testbench for the interval index classifier.
// ----------------------------------------------------------------------------
// Boundary lists and queries are sent on the slave stream. A local copy
// of the sorted table predicts each lookup result. A checker compares every
// master transaction with the oldest prediction. Both sides idle at random.
// The receiver also holds off for one long stretch so the block stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module interval_index_classifier_test;

    import iic_pkg::*;

    localparam int LOAD_SETTLE = 2 * MAX_ENTRIES + 16;
    localparam int ITEM_GOAL   = 820;

    typedef struct {
        logic [INDEX_BITS-1:0] index;
        logic [VALUE_BITS-1:0] value;
    } t_lookup;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  i_s_axis_tuser = 1'b0;
    logic                  i_s_axis_tlast = 1'b0;
    logic                  i_m_axis_tready = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    // lookup table copy
    logic signed [VALUE_BITS-1:0] bnd_tab [MAX_ENTRIES];
    int                           bnd_count = 0;
    int                           taken_count = 0;
    bit                           list_active = 1'b0;
    int                           list_elems = 0;

    t_lookup pending_lookups [$];

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_hold_cycles = 0;

    int error_count = 0;
    int items_sent = 0;
    int loads_sent = 0;
    int queries_sent = 0;
    int lists_closed = 0;
    int longest_list = 0;
    int results_seen = 0;

    interval_index_classifier u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),  // value
        .i_s_axis_tuser  (i_s_axis_tuser),  // opcode
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)   // index, passed_value
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("%0t: timeout, %0d lookups still pending", $time, pending_lookups.size());
        $display("Some tests failed");
        $finish;
    end

    task automatic absorb_boundary(input logic signed [VALUE_BITS-1:0] v, input logic lst);
        int pos;
        int k;
        if (!list_active) begin
            bnd_count   = 0;
            taken_count = 0;
            list_elems  = 0;
            list_active = 1'b1;
        end
        list_elems++;
        if (taken_count < MAX_ENTRIES) begin
            taken_count++;
            pos = 0;
            while (pos < bnd_count && bnd_tab[pos] < v) pos++;
            if (!(pos < bnd_count && bnd_tab[pos] == v) && bnd_count < MAX_ENTRIES) begin
                for (k = bnd_count; k > pos; k--) bnd_tab[k] = bnd_tab[k-1];
                bnd_tab[pos] = v;
                bnd_count++;
            end
        end
        if (lst) begin
            list_active = 1'b0;
            lists_closed++;
            if (list_elems > longest_list) longest_list = list_elems;
        end
    endtask

    function automatic logic [INDEX_BITS-1:0] interval_of(input logic signed [VALUE_BITS-1:0] v);
        int idx;
        idx = bnd_count + 1;
        for (int i = 0; i < bnd_count; i++) begin
            if (v < bnd_tab[i]) begin
                idx = i + 1;
                break;
            end
        end
        return idx[INDEX_BITS-1:0];
    endfunction

    // entered at a rising edge, returns at the edge that accepts the item
    task automatic send_item(input logic op, input logic [VALUE_BITS-1:0] val, input logic lst);
        int  gap;
        bit  taken;
        gap = 0;
        if (tx_idle_on) begin
            while ($urandom_range(99) < 23) gap++;
        end
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= val;
        i_s_axis_tuser  <= op;
        i_s_axis_tlast  <= lst;
        do begin
            @(negedge i_clk);
            taken = o_s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        items_sent++;
        if (op == OP_QUERY) begin
            pending_lookups.push_back('{index: interval_of(val), value: val});
            queries_sent++;
        end else begin
            absorb_boundary(val, lst);
            loads_sent++;
        end
    endtask

    task automatic pause_until_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (LOAD_SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_boundary(input int unsigned mode);
        case (mode)
            0: return $urandom;
            1: return (int'($urandom_range(16)) - 8) <<< 16;
            default: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    default: return (int'($urandom_range(64)) - 32) * 4096;
                endcase
            end
        endcase
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_query();
        int unsigned r;
        r = $urandom_range(99);
        if (bnd_count > 0 && r < 60)
            return bnd_tab[$urandom_range(bnd_count - 1)] + (int'($urandom_range(2)) - 1);
        else if (r < 80)
            return pick_boundary($urandom_range(1, 2));
        else
            return $urandom;
    endfunction

    task automatic test_empty_table();
        send_item(OP_QUERY, 32'h0000_0000, 1'b0);
        send_item(OP_QUERY, 32'h8000_0000, 1'b1);
        send_item(OP_QUERY, 32'h7FFF_FFFF, 1'b0);
    endtask

    task automatic test_directed_list();
        send_item(OP_LOAD,  32'h0001_0000, 1'b0);
        send_item(OP_LOAD,  32'hFFFF_0000, 1'b0);
        send_item(OP_QUERY, 32'h0001_0000, 1'b0);
        send_item(OP_LOAD,  32'h0001_0000, 1'b0);
        send_item(OP_LOAD,  32'h7FFF_FFFF, 1'b0);
        send_item(OP_LOAD,  32'h8000_0000, 1'b0);
        send_item(OP_LOAD,  32'h0000_0000, 1'b1);
        send_item(OP_QUERY, 32'h8000_0000, 1'b0);
        send_item(OP_QUERY, 32'h7FFF_FFFF, 1'b0);
        send_item(OP_QUERY, 32'h0000_0000, 1'b0);
        send_item(OP_QUERY, 32'hFFFF_FFFF, 1'b0);
        send_item(OP_QUERY, 32'h0001_0001, 1'b0);
        send_item(OP_QUERY, 32'h0000_8000, 1'b1);
        send_item(OP_LOAD,  32'h0002_0000, 1'b1);
        send_item(OP_QUERY, 32'h0000_0000, 1'b0);
        send_item(OP_QUERY, 32'h0002_0000, 1'b0);
    endtask

    task automatic test_overlong_list();
        for (int i = 0; i < 70; i++) send_item(OP_LOAD, pick_boundary(0), i == 69);
        send_item(OP_QUERY, 32'h7FFF_FFFF, 1'b0);
        send_item(OP_QUERY, 32'h8000_0000, 1'b0);
        repeat (6) send_item(OP_QUERY, pick_query(), 1'($urandom_range(1)));
        // many repeats, last mark on a dropped element
        for (int i = 0; i < 67; i++) send_item(OP_LOAD, pick_boundary(1), i == 66);
        repeat (6) send_item(OP_QUERY, pick_query(), 1'($urandom_range(1)));
    endtask

    task automatic test_back_pressure();
        rx_hold_cycles = 300;
        repeat (14) send_item(OP_QUERY, pick_query(), 1'($urandom_range(1)));
        pause_until_drained();
        send_item(OP_LOAD, pick_boundary(2), 1'b1);
        send_item(OP_QUERY, pick_query(), 1'b0);
    endtask

    task automatic test_no_idle_burst();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (int i = 0; i < 20; i++) send_item(OP_LOAD, pick_boundary(2), i == 19);
        repeat (30) send_item(OP_QUERY, pick_query(), 1'($urandom_range(1)));
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_lists();
        int unsigned len;
        int unsigned mode;
        int unsigned r;
        while (items_sent < ITEM_GOAL) begin
            if ($urandom_range(99) < 82) begin
                mode = $urandom_range(2);
                r    = $urandom_range(99);
                len  = (r < 85) ? $urandom_range(1, 8) :
                       (r < 97) ? $urandom_range(9, 64) : $urandom_range(65, 72);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(99) < 8)
                        send_item(OP_QUERY, pick_query(), 1'($urandom_range(1)));
                    send_item(OP_LOAD, pick_boundary(mode), i == len - 1);
                end
                repeat ($urandom_range(1, 6))
                    send_item(OP_QUERY, pick_query(), 1'($urandom_range(1)));
            end else begin
                send_item(1'($urandom_range(1)), pick_boundary($urandom_range(2)),
                          1'($urandom_range(1)));
            end
        end
    endtask

    initial begin : result_checker
        t_lookup               want;
        logic [INDEX_BITS-1:0] got_index;
        logic [VALUE_BITS-1:0] got_value;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                got_index = o_m_axis_tdata[INDEX_BITS-1:0];
                got_value = o_m_axis_tdata[INDEX_BITS +: VALUE_BITS];
                results_seen++;
                if (pending_lookups.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual index %0d value %h",
                             $time, got_index, got_value);
                    error_count++;
                end else begin
                    want = pending_lookups.pop_front();
                    if (got_index !== want.index) begin
                        $display("%0t: index mismatch, expected %0d, actual %0d",
                                 $time, want.index, got_index);
                        error_count++;
                    end
                    if (got_value !== want.value) begin
                        $display("%0t: passed_value mismatch, expected %h, actual %h",
                                 $time, want.value, got_value);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin : rx_ready_driver
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles > 0) begin
                i_m_axis_tready <= 1'b0;
                rx_hold_cycles--;
            end else begin
                i_m_axis_tready <= !(rx_idle_on && $urandom_range(99) < 23);
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_directed_list();
        test_overlong_list();
        test_back_pressure();
        test_no_idle_burst();
        test_random_lists();
        pause_until_drained();
        if (pending_lookups.size() != 0) begin
            $display("%0t: %0d lookups never returned", $time, pending_lookups.size());
            error_count++;
        end
        $display("covered %0d boundary loads in %0d closed lists (longest %0d)",
                 loads_sent, lists_closed, longest_list);
        $display("and %0d queries, %0d result transactions checked", queries_sent, results_seen);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
